### design/sstc_pkg.sv
// Shared constants, types and helpers for the segment set thrackle check.
// No dependencies; used by the top level and by its checker.
package sstc_pkg;

    localparam int MAX_EDGES  = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_EDGES);
    localparam int CNT_BITS   = $clog2(MAX_EDGES + 1);
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CR_W       = PROD_W + 1;

    typedef logic [COORD_BITS-1:0]     coord_t;
    typedef logic [CNT_BITS-1:0]       cnt_t;
    typedef logic [IDX_BITS-1:0]       idx_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CR_W-1:0]    cr_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
    } seg_t;

    // exact signed difference of two unsigned coordinates
    function automatic diff_t coord_diff(input coord_t a, input coord_t b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    function automatic logic share_end(input seg_t p, input seg_t q);
        return (p.ax == q.ax && p.ay == q.ay) || (p.ax == q.bx && p.ay == q.by) ||
               (p.bx == q.ax && p.by == q.ay) || (p.bx == q.bx && p.by == q.by);
    endfunction

endpackage

### design/segment_set_thrackle_check.sv
// Top level of the segment set thrackle check: edge store, scan sequencer
// and pipelined pair test. Depends on sstc_pkg.
//
// Busy stays high from a transfer through the scan, drain and commit states; with
// an empty or full store the scan and drain are skipped. The scan reads one stored
// edge per cycle from the edge memory. A new edge is taken only back in idle, once
// the previous edge has been committed.
// The verdict strobe (done) follows the last edge's commit cycle; no stall input.
// Reset (rst_n low, async) empties the set; the edge memory itself is not cleared.
module segment_set_thrackle_check
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sstc_pkg::COORD_BITS-1:0] first_x,
    input  logic [sstc_pkg::COORD_BITS-1:0] first_y,
    input  logic [sstc_pkg::COORD_BITS-1:0] second_x,
    input  logic [sstc_pkg::COORD_BITS-1:0] second_y,
    input  logic                          last_edge,
    output logic                          done,
    output logic                          is_thrackle,
    output logic                          overflow,
    output logic [sstc_pkg::CNT_BITS-1:0] edge_total
);

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;  // waiting for a transfer
    localparam logic [1:0] ST_SCAN   = 2'd1;  // issuing one memory read per cycle
    localparam logic [1:0] ST_DRAIN  = 2'd2;  // letting the pair pipeline empty
    localparam logic [1:0] ST_COMMIT = 2'd3;  // store edge, maybe report verdict

    logic [1:0]       state_reg, state_next;
    sstc_pkg::cnt_t   count_reg, count_next;
    sstc_pkg::idx_t   rd_idx_reg, rd_idx_next;
    logic             ok_reg;
    logic             ovf_reg;
    sstc_pkg::seg_t   edge_reg;
    logic             last_reg;

    logic             done_reg;
    logic             thr_reg;
    logic             ovf_out_reg;
    sstc_pkg::cnt_t   total_reg;

    logic             accept;
    logic             full;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign full   = (count_reg == sstc_pkg::CNT_BITS'(sstc_pkg::MAX_EDGES));

    // ------------------------------------------------------------------
    // Edge memory: one write port (commit), one registered read port (scan)
    // ------------------------------------------------------------------
    sstc_pkg::seg_t   mem [sstc_pkg::MAX_EDGES];
    sstc_pkg::seg_t   rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COMMIT && !full)
        begin
            mem[count_reg[sstc_pkg::IDX_BITS-1:0]] <= edge_reg;
        end
        if (state_reg == ST_SCAN)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg;   // pipeline stage valids

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                rd_idx_next = '0;
                if (accept)
                begin
                    // empty store: nothing to compare against; full store: edge is dropped unchecked
                    if (count_reg == '0 || full)
                        state_next = ST_COMMIT;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                rd_idx_next = rd_idx_reg + sstc_pkg::IDX_BITS'(1);
                if ({1'b0, rd_idx_reg} == count_reg - sstc_pkg::CNT_BITS'(1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
                if (last_reg)
                    count_next = '0;
                else if (!full)
                    count_next = count_reg + sstc_pkg::CNT_BITS'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    // captured edge
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            edge_reg <= '{ax: first_x, ay: first_y, bx: second_x, by: second_y};
            last_reg <= last_edge;
        end
    end

    // ------------------------------------------------------------------
    // Pair test pipeline. p is the new edge, q the stored one.
    // Stage A: differences and shared-endpoint compare.
    // Stage B: the eight cross-product terms.
    // Stage C: four strict left-of signs, verdict folded into ok_reg.
    // ------------------------------------------------------------------
    sstc_pkg::diff_t dpx_reg, dpy_reg, dqx_reg, dqy_reg;
    sstc_pkg::diff_t qapa_x_reg, qapa_y_reg, qbpa_x_reg, qbpa_y_reg;
    sstc_pkg::diff_t paqa_x_reg, paqa_y_reg, pbqa_x_reg, pbqa_y_reg;
    logic            common_a_reg, common_b_reg;

    sstc_pkg::prod_t m1a_reg, m1b_reg, m2a_reg, m2b_reg;
    sstc_pkg::prod_t m3a_reg, m3b_reg, m4a_reg, m4b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= (state_reg == ST_SCAN);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage A
        dpx_reg      <= sstc_pkg::coord_diff(edge_reg.bx, edge_reg.ax);
        dpy_reg      <= sstc_pkg::coord_diff(edge_reg.by, edge_reg.ay);
        dqx_reg      <= sstc_pkg::coord_diff(rd_data_reg.bx, rd_data_reg.ax);
        dqy_reg      <= sstc_pkg::coord_diff(rd_data_reg.by, rd_data_reg.ay);
        qapa_x_reg   <= sstc_pkg::coord_diff(rd_data_reg.ax, edge_reg.ax);
        qapa_y_reg   <= sstc_pkg::coord_diff(rd_data_reg.ay, edge_reg.ay);
        qbpa_x_reg   <= sstc_pkg::coord_diff(rd_data_reg.bx, edge_reg.ax);
        qbpa_y_reg   <= sstc_pkg::coord_diff(rd_data_reg.by, edge_reg.ay);
        paqa_x_reg   <= sstc_pkg::coord_diff(edge_reg.ax, rd_data_reg.ax);
        paqa_y_reg   <= sstc_pkg::coord_diff(edge_reg.ay, rd_data_reg.ay);
        pbqa_x_reg   <= sstc_pkg::coord_diff(edge_reg.bx, rd_data_reg.ax);
        pbqa_y_reg   <= sstc_pkg::coord_diff(edge_reg.by, rd_data_reg.ay);
        common_a_reg <= sstc_pkg::share_end(edge_reg, rd_data_reg);
        // stage B
        m1a_reg      <= sstc_pkg::prod_t'(dpx_reg) * sstc_pkg::prod_t'(qapa_y_reg);
        m1b_reg      <= sstc_pkg::prod_t'(qapa_x_reg) * sstc_pkg::prod_t'(dpy_reg);
        m2a_reg      <= sstc_pkg::prod_t'(dpx_reg) * sstc_pkg::prod_t'(qbpa_y_reg);
        m2b_reg      <= sstc_pkg::prod_t'(qbpa_x_reg) * sstc_pkg::prod_t'(dpy_reg);
        m3a_reg      <= sstc_pkg::prod_t'(dqx_reg) * sstc_pkg::prod_t'(paqa_y_reg);
        m3b_reg      <= sstc_pkg::prod_t'(paqa_x_reg) * sstc_pkg::prod_t'(dqy_reg);
        m4a_reg      <= sstc_pkg::prod_t'(dqx_reg) * sstc_pkg::prod_t'(pbqa_y_reg);
        m4b_reg      <= sstc_pkg::prod_t'(pbqa_x_reg) * sstc_pkg::prod_t'(dqy_reg);
        common_b_reg <= common_a_reg;
    end

    // stage C
    sstc_pkg::cr_t cr1, cr2, cr3, cr4;
    logic          crosses;
    logic          pair_bad;

    always_comb
    begin
        cr1      = sstc_pkg::cr_t'(m1a_reg) - sstc_pkg::cr_t'(m1b_reg);
        cr2      = sstc_pkg::cr_t'(m2a_reg) - sstc_pkg::cr_t'(m2b_reg);
        cr3      = sstc_pkg::cr_t'(m3a_reg) - sstc_pkg::cr_t'(m3b_reg);
        cr4      = sstc_pkg::cr_t'(m4a_reg) - sstc_pkg::cr_t'(m4b_reg);
        // strict left-of flags differ on both lines (an endpoint on a line counts as not left)
        crosses  = ((cr1 > 0) != (cr2 > 0)) && ((cr3 > 0) != (cr4 > 0));
        pair_bad = !(common_b_reg || crosses);
    end

    // set flags and the verdict register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg   <= 1'b1;
            ovf_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_COMMIT) && last_reg;
            if (state_reg == ST_COMMIT && last_reg)
            begin
                ok_reg  <= 1'b1;
                ovf_reg <= 1'b0;
            end
            else
            begin
                if (v3_reg && pair_bad)
                    ok_reg <= 1'b0;
                if (state_reg == ST_COMMIT && full)
                    ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_COMMIT && last_reg)
        begin
            thr_reg     <= ok_reg;
            ovf_out_reg <= ovf_reg || full;
            total_reg   <= full ? count_reg : count_reg + sstc_pkg::CNT_BITS'(1);
        end
    end

    assign done        = done_reg;
    assign is_thrackle = thr_reg;
    assign overflow    = ovf_out_reg;
    assign edge_total  = total_reg;

endmodule

### design/sstc_checker.sv
// Port-level checker for segment_set_thrackle_check, with its bind.
// Depends on sstc_pkg.
module sstc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic                          overflow,
    input logic [sstc_pkg::CNT_BITS-1:0] edge_total
);

    // a transfer always starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not raise busy");

    // verdict comes out once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("verdict while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("verdict strobe longer than one cycle");

    // overflow only happens with a full store
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (edge_total == sstc_pkg::CNT_BITS'(sstc_pkg::MAX_EDGES)))
        else $error("overflow reported on a store that is not full");

    // a set whose last edge was stored is never empty
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !overflow) |-> (edge_total != '0))
        else $error("empty set reported");

endmodule

bind segment_set_thrackle_check sstc_checker u_sstc_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .overflow   (overflow),
    .edge_total (edge_total)
);
